/* rtl/core/ekc_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, defaults and codes for the eikonal cell update block.
package ekc_pkg;

   localparam int VAL_W     = 40;
   localparam int CNT_W     = 7;
   localparam int COORD_W   = 6;
   localparam int FUNC_W    = 2;
   localparam int PATH_W    = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CMP_W     = 9;

   localparam int MAX_SIDE_DEF      = 64;
   localparam int FRACTION_BITS_DEF = 20;

   // weights are squared counts, pair weights are products of two weights
   localparam int WT_W   = 2 * CNT_W;
   localparam int WSUM_W = WT_W + 2;
   localparam int PROD_W = 2 * WT_W;
   localparam int SQ_W   = 2 * VAL_W;
   localparam int ACC_W  = SQ_W + PROD_W + 2;
   localparam int RAD_W  = SQ_W + WSUM_W;
   localparam int ROOT_W = RAD_W / 2;
   localparam int NUM_W  = VAL_W + WT_W + 2;

   localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

   localparam logic [FUNC_W-1:0] FUNC_LOAD_TIME  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_SPEED = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_UPDATE     = 2'd2;

   localparam logic [PATH_W-1:0] PATH_3D = 2'd0;
   localparam logic [PATH_W-1:0] PATH_XY = 2'd1;
   localparam logic [PATH_W-1:0] PATH_Y  = 2'd2;
   localparam logic [PATH_W-1:0] PATH_X  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_Z = 2'd2;

   localparam logic [CNT_W-1:0] RST_CELLS_X = 7'd64;
   localparam logic [CNT_W-1:0] RST_CELLS_Y = 7'd64;
   localparam logic [CNT_W-1:0] RST_CELLS_Z = 7'd1;

endpackage

/* rtl/core/ekc_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module ekc_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/ekc_mul.sv */
`timescale 1ns / 1ps
// Bit-serial shift-add multiply-accumulate: one multiplier bit per cycle.
module ekc_mul #(
   parameter int A_W = 80,
   parameter int B_W = 40,
   parameter int P_W = 110
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [A_W-1:0] a,
   input  logic [B_W-1:0] b,
   input  logic [P_W-1:0] init,
   output logic           busy,
   output logic           done,
   output logic [P_W-1:0] prod
);

   logic [P_W-1:0] mcand_ff;
   logic [B_W-1:0] mplier_ff;
   logic [P_W-1:0] acc_ff;
   logic           busy_ff;
   logic           done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         mcand_ff  <= {{(P_W-A_W){1'b0}}, a};
         mplier_ff <= b;
         acc_ff    <= init;
         busy_ff   <= 1'b1;
         done_ff   <= 1'b0;
      end else if (busy_ff) begin
         // stop early once no set multiplier bits remain
         if (mplier_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end else begin
            if (mplier_ff[0]) begin
               acc_ff <= acc_ff + mcand_ff;
            end
            mcand_ff  <= {mcand_ff[P_W-2:0], 1'b0};
            mplier_ff <= {1'b0, mplier_ff[B_W-1:1]};
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign prod = acc_ff;

endmodule

/* rtl/core/ekc_div.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module ekc_div #(
   parameter int N_W = 56,
   parameter int D_W = 40
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] dividend,
   input  logic [D_W-1:0] divisor,
   output logic           busy,
   output logic           done,
   output logic [N_W-1:0] quotient
);

   localparam int C_W = $clog2(N_W + 1);

   logic [N_W-1:0] quo_ff;
   logic [D_W-1:0] rem_ff;
   logic [D_W-1:0] dsr_ff;
   logic [C_W-1:0] cnt_ff;
   logic           busy_ff;
   logic           done_ff;
   logic [D_W:0]   trial;
   logic [D_W:0]   diff;
   logic           ge;

   assign trial = {rem_ff, quo_ff[N_W-1]};
   assign ge    = trial >= {1'b0, dsr_ff};
   assign diff  = trial - {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         quo_ff  <= dividend;
         rem_ff  <= '0;
         dsr_ff  <= divisor;
         cnt_ff  <= C_W'(N_W);
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
         quo_ff <= {quo_ff[N_W-2:0], ge};
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == C_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/core/ekc_sqrt.sv */
`timescale 1ns / 1ps
// Digit-by-digit integer square root, two radicand bits per cycle.
module ekc_sqrt #(
   parameter int R_W = 96
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [R_W-1:0]   radicand,
   output logic             busy,
   output logic             done,
   output logic [R_W/2-1:0] root
);

   localparam int Q_W = R_W / 2;
   localparam int C_W = $clog2(Q_W + 1);

   logic [R_W-1:0] rad_ff;
   logic [Q_W:0]   rem_ff;
   logic [Q_W-1:0] root_ff;
   logic [C_W-1:0] cnt_ff;
   logic           busy_ff;
   logic           done_ff;
   logic [Q_W+2:0] cur;
   logic [Q_W+2:0] trial;
   logic [Q_W+2:0] diff;
   logic           ge;

   assign cur   = {rem_ff, rad_ff[R_W-1:R_W-2]};
   assign trial = {1'b0, root_ff, 2'b01};
   assign ge    = cur >= trial;
   assign diff  = cur - trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= C_W'(Q_W);
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff) begin
         rem_ff  <= ge ? diff[Q_W:0] : cur[Q_W:0];
         root_ff <= {root_ff[Q_W-2:0], ge};
         rad_ff  <= {rad_ff[R_W-3:0], 2'b00};
         cnt_ff  <= cnt_ff - 1'b1;
         if (cnt_ff == C_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign root = root_ff;

endmodule

/* rtl/core/eikonal_cell_update_3d_top.sv */
`timescale 1ns / 1ps
// Eikonal cell update: grid stores, neighbor reads and serial solve sequencer.
// Loads are written at the accepting edge and req_ready stays high, so loads run back to back.
// An update holds req_ready low through the neighbor reads, a slowness divide, at most eleven
// serial multiplies, a square root and a final or step divide; a zero speed skips the arithmetic,
// and the result also waits while the previous output word is still held.
// Reset clears the sequencer and output word and sets the cell counts to 64, 64, 1.
module eikonal_cell_update_3d_top #(
   parameter int MAX_SIDE      = ekc_pkg::MAX_SIDE_DEF,
   parameter int FRACTION_BITS = ekc_pkg::FRACTION_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [ekc_pkg::FUNC_W-1:0]     req_func,
   input  logic [ekc_pkg::COORD_W-1:0]    req_cell_x,
   input  logic [ekc_pkg::COORD_W-1:0]    req_cell_y,
   input  logic [ekc_pkg::COORD_W-1:0]    req_cell_z,
   input  logic [ekc_pkg::VAL_W-1:0]      req_load_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [ekc_pkg::VAL_W-1:0]      rsp_new_time,
   output logic [ekc_pkg::PATH_W-1:0]     rsp_solve_path,
   input  logic                           csr_wr_en,
   input  logic [ekc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ekc_pkg::CNT_W-1:0]      csr_wdata
);

   localparam int VAL_W   = ekc_pkg::VAL_W;
   localparam int CNT_W   = ekc_pkg::CNT_W;
   localparam int COORD_W = ekc_pkg::COORD_W;
   localparam int CMP_W   = ekc_pkg::CMP_W;
   localparam int WT_W    = ekc_pkg::WT_W;
   localparam int WSUM_W  = ekc_pkg::WSUM_W;
   localparam int PROD_W  = ekc_pkg::PROD_W;
   localparam int SQ_W    = ekc_pkg::SQ_W;
   localparam int ACC_W   = ekc_pkg::ACC_W;
   localparam int RAD_W   = ekc_pkg::RAD_W;
   localparam int ROOT_W  = ekc_pkg::ROOT_W;
   localparam int NUM_W   = ekc_pkg::NUM_W;
   localparam int PATH_W  = ekc_pkg::PATH_W;
   localparam int SIDE_W  = $clog2(MAX_SIDE);
   localparam int ADDR_W  = 3 * SIDE_W;
   localparam int DEPTH   = 1 << ADDR_W;
   localparam int DIVN_W  = (2 * FRACTION_BITS + 1 > NUM_W) ? 2 * FRACTION_BITS + 1 : NUM_W;
   localparam logic [2:0] RD_LAST = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_CHK, ST_SLOW, ST_MUL, ST_CMP3, ST_CMP2,
      ST_SQRT, ST_DIVN, ST_STEP, ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      MOP_FF, MOP_POS3, MOP_SQXY, MOP_NXY, MOP_SQYZ, MOP_NYZ, MOP_SQXZ, MOP_NXZ,
      MOP_POS2, MOP_NUMX, MOP_NUMY, MOP_NUMZ
   } mop_type;

   // ---------------- configuration ----------------
   logic [CNT_W-1:0] cells_x_ff, cells_y_ff, cells_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_x_ff <= ekc_pkg::RST_CELLS_X;
         cells_y_ff <= ekc_pkg::RST_CELLS_Y;
         cells_z_ff <= ekc_pkg::RST_CELLS_Z;
      end else if (csr_wr_en) begin
         case (csr_index)
            ekc_pkg::CSR_CELLS_X: cells_x_ff <= csr_wdata;
            ekc_pkg::CSR_CELLS_Y: cells_y_ff <= csr_wdata;
            ekc_pkg::CSR_CELLS_Z: cells_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   function automatic logic [CNT_W-1:0] count_of(input logic [CNT_W-1:0] r);
      logic [CNT_W-1:0] n;
      n = r;
      if (r == '0) begin
         n = CNT_W'(1);
      end else if (CMP_W'(r) > CMP_W'(MAX_SIDE)) begin
         n = CNT_W'(MAX_SIDE);
      end
      return n;
   endfunction

   function automatic logic [CMP_W-1:0] clamp_upd(input logic [CMP_W-1:0] c,
                                                  input logic [CNT_W-1:0] n);
      logic [CMP_W-1:0] n9;
      n9 = CMP_W'(n);
      return (c >= n9) ? n9 - 1'b1 : c;
   endfunction

   function automatic logic [CMP_W-1:0] clamp_load(input logic [COORD_W-1:0] c);
      logic [CMP_W-1:0] c9;
      c9 = CMP_W'(c);
      return (c9 >= CMP_W'(MAX_SIDE)) ? CMP_W'(MAX_SIDE - 1) : c9;
   endfunction

   function automatic logic [ADDR_W-1:0] addr_of(input logic [CMP_W-1:0] x,
                                                 input logic [CMP_W-1:0] y,
                                                 input logic [CMP_W-1:0] z);
      return {z[SIDE_W-1:0], y[SIDE_W-1:0], x[SIDE_W-1:0]};
   endfunction

   function automatic logic [VAL_W-1:0] sat_q(input logic [DIVN_W-1:0] q);
      return (|q[DIVN_W-1:VAL_W]) ? ekc_pkg::VAL_MAX : q[VAL_W-1:0];
   endfunction

   function automatic logic [VAL_W-1:0] adiff(input logic [VAL_W-1:0] a,
                                              input logic [VAL_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   // ---------------- sequencer registers ----------------
   state_type          state_ff;
   mop_type            mop_ff;
   logic               run_ff;
   logic [2:0]         rd_cnt_ff;
   logic [CNT_W-1:0]   nx_ff, ny_ff, nz_ff;
   logic [CMP_W-1:0]   x_ff, y_ff, z_ff;
   logic [VAL_W-1:0]   v_ff, tmp_ff, ux_ff, uy_ff, uz_ff;
   logic [WT_W-1:0]    wx_ff, wy_ff, wz_ff;
   logic [PROD_W-1:0]  wxy_ff, wyz_ff, wxz_ff;
   logic [WSUM_W-1:0]  w3_ff, w2_ff;
   logic [VAL_W-1:0]   f_ff, dxy_ff, dyz_ff, dxz_ff;
   logic [SQ_W-1:0]    f2_ff, sq_ff;
   logic [ACC_W-1:0]   pos3_ff, pos2_ff, neg3_ff, neg2_ff;
   logic [ROOT_W-1:0]  root_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [CNT_W-1:0]   nstep_ff;
   logic [VAL_W-1:0]   ustep_ff;
   logic [VAL_W-1:0]   res_time_ff;
   logic [PATH_W-1:0]  path_ff;
   logic               rsp_valid_ff;
   logic [VAL_W-1:0]   rsp_time_ff;
   logic [PATH_W-1:0]  rsp_path_ff;

   logic accept;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // ---------------- stores ----------------
   logic              time_we, speed_we;
   logic [ADDR_W-1:0] wr_addr, time_rd_addr, speed_rd_addr;
   logic [VAL_W-1:0]  time_rd_data, speed_rd_data;
   logic [CMP_W-1:0]  xm, xp, ym, yp, zm, zp;

   assign time_we  = accept && (req_func == ekc_pkg::FUNC_LOAD_TIME);
   assign speed_we = accept && (req_func == ekc_pkg::FUNC_LOAD_SPEED);
   assign wr_addr  = addr_of(clamp_load(req_cell_x), clamp_load(req_cell_y),
                             clamp_load(req_cell_z));

   assign xm = (x_ff == '0) ? '0 : x_ff - 1'b1;
   assign ym = (y_ff == '0) ? '0 : y_ff - 1'b1;
   assign zm = (z_ff == '0) ? '0 : z_ff - 1'b1;
   assign xp = clamp_upd(x_ff + 1'b1, nx_ff);
   assign yp = clamp_upd(y_ff + 1'b1, ny_ff);
   assign zp = clamp_upd(z_ff + 1'b1, nz_ff);

   assign speed_rd_addr = addr_of(x_ff, y_ff, z_ff);

   always_comb begin
      case (rd_cnt_ff)
         3'd0:    time_rd_addr = addr_of(xm, y_ff, z_ff);
         3'd1:    time_rd_addr = addr_of(xp, y_ff, z_ff);
         3'd2:    time_rd_addr = addr_of(x_ff, ym, z_ff);
         3'd3:    time_rd_addr = addr_of(x_ff, yp, z_ff);
         3'd4:    time_rd_addr = addr_of(x_ff, y_ff, zm);
         3'd5:    time_rd_addr = addr_of(x_ff, y_ff, zp);
         default: time_rd_addr = addr_of(x_ff, y_ff, z_ff);
      endcase
   end

   ekc_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_time_ram (
      .clock   (clock),
      .wr_en   (time_we),
      .wr_addr (wr_addr),
      .wr_data (req_load_value),
      .rd_addr (time_rd_addr),
      .rd_data (time_rd_data)
   );

   ekc_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_speed_ram (
      .clock   (clock),
      .wr_en   (speed_we),
      .wr_addr (wr_addr),
      .wr_data (req_load_value),
      .rd_addr (speed_rd_addr),
      .rd_data (speed_rd_data)
   );

   // ---------------- serial units ----------------
   logic              mul_start, mul_busy, mul_done;
   logic [SQ_W-1:0]   mul_a;
   logic [VAL_W-1:0]  mul_b;
   logic [ACC_W-1:0]  mul_init, mul_prod;

   always_comb begin
      mul_a    = SQ_W'(f_ff);
      mul_b    = f_ff;
      mul_init = '0;
      case (mop_ff)
         MOP_FF: ;
         MOP_POS3: begin
            mul_a = f2_ff;
            mul_b = VAL_W'(w3_ff);
         end
         MOP_SQXY: begin
            mul_a = SQ_W'(dxy_ff);
            mul_b = dxy_ff;
         end
         MOP_NXY: begin
            mul_a = sq_ff;
            mul_b = VAL_W'(wxy_ff);
         end
         MOP_SQYZ: begin
            mul_a = SQ_W'(dyz_ff);
            mul_b = dyz_ff;
         end
         MOP_NYZ: begin
            mul_a    = sq_ff;
            mul_b    = VAL_W'(wyz_ff);
            mul_init = neg2_ff;
         end
         MOP_SQXZ: begin
            mul_a = SQ_W'(dxz_ff);
            mul_b = dxz_ff;
         end
         MOP_NXZ: begin
            mul_a    = sq_ff;
            mul_b    = VAL_W'(wxz_ff);
            mul_init = neg3_ff;
         end
         MOP_POS2: begin
            mul_a = f2_ff;
            mul_b = VAL_W'(w2_ff);
         end
         MOP_NUMX: begin
            mul_a    = SQ_W'(ux_ff);
            mul_b    = VAL_W'(wx_ff);
            mul_init = ACC_W'(root_ff);
         end
         MOP_NUMY: begin
            mul_a    = SQ_W'(uy_ff);
            mul_b    = VAL_W'(wy_ff);
            mul_init = ACC_W'(num_ff);
         end
         MOP_NUMZ: begin
            mul_a    = SQ_W'(uz_ff);
            mul_b    = VAL_W'(wz_ff);
            mul_init = ACC_W'(num_ff);
         end
         default: ;
      endcase
   end

   assign mul_start = (state_ff == ST_MUL) && !run_ff;

   ekc_mul #(.A_W(SQ_W), .B_W(VAL_W), .P_W(ACC_W)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .init  (mul_init),
      .busy  (mul_busy),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   logic              div_start, div_busy, div_done;
   logic [DIVN_W-1:0] div_dividend, div_quot;
   logic [VAL_W-1:0]  div_divisor;

   always_comb begin
      case (state_ff)
         ST_SLOW: begin
            div_dividend = DIVN_W'(1'b1) << (2 * FRACTION_BITS);
            div_divisor  = v_ff;
         end
         ST_STEP: begin
            div_dividend = DIVN_W'(f_ff);
            div_divisor  = VAL_W'(nstep_ff);
         end
         default: begin
            div_dividend = DIVN_W'(num_ff);
            div_divisor  = (path_ff == ekc_pkg::PATH_3D) ? VAL_W'(w3_ff) : VAL_W'(w2_ff);
         end
      endcase
   end

   assign div_start = !run_ff &&
                      (state_ff == ST_SLOW || state_ff == ST_DIVN || state_ff == ST_STEP);

   ekc_div #(.N_W(DIVN_W), .D_W(VAL_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quot)
   );

   logic              sqrt_start, sqrt_busy, sqrt_done;
   logic [ACC_W-1:0]  rad_full;
   logic [ROOT_W-1:0] sqrt_root;

   assign rad_full   = (path_ff == ekc_pkg::PATH_3D) ? pos3_ff - neg3_ff : pos2_ff - neg2_ff;
   assign sqrt_start = (state_ff == ST_SQRT) && !run_ff;

   ekc_sqrt #(.R_W(RAD_W)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (rad_full[RAD_W-1:0]),
      .busy     (sqrt_busy),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   logic [VAL_W:0] step_sum;
   assign step_sum = {1'b0, ustep_ff} + {1'b0, div_quot[VAL_W-1:0]};

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mop_ff       <= MOP_FF;
         run_ff       <= 1'b0;
         rd_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in ST_OUT the output word is reloaded below instead
         if (rsp_valid_ff && rsp_ready && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept && req_func == ekc_pkg::FUNC_UPDATE) begin
                  nx_ff     <= count_of(cells_x_ff);
                  ny_ff     <= count_of(cells_y_ff);
                  nz_ff     <= count_of(cells_z_ff);
                  x_ff      <= clamp_upd(CMP_W'(req_cell_x), count_of(cells_x_ff));
                  y_ff      <= clamp_upd(CMP_W'(req_cell_y), count_of(cells_y_ff));
                  z_ff      <= clamp_upd(CMP_W'(req_cell_z), count_of(cells_z_ff));
                  rd_cnt_ff <= '0;
                  state_ff  <= ST_READ;
               end
            end
            ST_READ: begin
               rd_cnt_ff <= rd_cnt_ff + 1'b1;
               // read data is registered, so it arrives in the cycle after its address
               case (rd_cnt_ff)
                  3'd0: begin
                     wx_ff <= WT_W'(nx_ff) * WT_W'(nx_ff);
                     wy_ff <= WT_W'(ny_ff) * WT_W'(ny_ff);
                     wz_ff <= WT_W'(nz_ff) * WT_W'(nz_ff);
                  end
                  3'd1: begin
                     v_ff   <= speed_rd_data;
                     tmp_ff <= time_rd_data;
                     wxy_ff <= PROD_W'(wx_ff) * PROD_W'(wy_ff);
                     w3_ff  <= WSUM_W'(wx_ff) + WSUM_W'(wy_ff) + WSUM_W'(wz_ff);
                     w2_ff  <= WSUM_W'(wx_ff) + WSUM_W'(wy_ff);
                  end
                  3'd2: begin
                     ux_ff  <= (tmp_ff < time_rd_data) ? tmp_ff : time_rd_data;
                     wyz_ff <= PROD_W'(wy_ff) * PROD_W'(wz_ff);
                  end
                  3'd3: begin
                     tmp_ff <= time_rd_data;
                     wxz_ff <= PROD_W'(wx_ff) * PROD_W'(wz_ff);
                  end
                  3'd4: uy_ff  <= (tmp_ff < time_rd_data) ? tmp_ff : time_rd_data;
                  3'd5: tmp_ff <= time_rd_data;
                  default: begin
                     uz_ff    <= (tmp_ff < time_rd_data) ? tmp_ff : time_rd_data;
                     state_ff <= ST_CHK;
                  end
               endcase
            end
            ST_CHK: begin
               dxy_ff <= adiff(ux_ff, uy_ff);
               dyz_ff <= adiff(uy_ff, uz_ff);
               dxz_ff <= adiff(ux_ff, uz_ff);
               run_ff <= 1'b0;
               if (v_ff == '0) begin
                  res_time_ff <= ekc_pkg::VAL_MAX;
                  path_ff     <= ekc_pkg::PATH_3D;
                  state_ff    <= ST_OUT;
               end else begin
                  state_ff <= ST_SLOW;
               end
            end
            ST_SLOW: begin
               if (!run_ff) begin
                  run_ff <= 1'b1;
               end else if (div_done) begin
                  run_ff   <= 1'b0;
                  f_ff     <= sat_q(div_quot);
                  mop_ff   <= MOP_FF;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               if (!run_ff) begin
                  run_ff <= 1'b1;
               end else if (mul_done) begin
                  run_ff <= 1'b0;
                  case (mop_ff)
                     MOP_FF: begin
                        f2_ff  <= mul_prod[SQ_W-1:0];
                        mop_ff <= MOP_POS3;
                     end
                     MOP_POS3: begin
                        pos3_ff <= mul_prod;
                        mop_ff  <= MOP_SQXY;
                     end
                     MOP_SQXY: begin
                        sq_ff  <= mul_prod[SQ_W-1:0];
                        mop_ff <= MOP_NXY;
                     end
                     MOP_NXY: begin
                        neg2_ff <= mul_prod;
                        mop_ff  <= MOP_SQYZ;
                     end
                     MOP_SQYZ: begin
                        sq_ff  <= mul_prod[SQ_W-1:0];
                        mop_ff <= MOP_NYZ;
                     end
                     MOP_NYZ: begin
                        neg3_ff <= mul_prod;
                        mop_ff  <= MOP_SQXZ;
                     end
                     MOP_SQXZ: begin
                        sq_ff  <= mul_prod[SQ_W-1:0];
                        mop_ff <= MOP_NXZ;
                     end
                     MOP_NXZ: begin
                        neg3_ff  <= mul_prod;
                        state_ff <= ST_CMP3;
                     end
                     MOP_POS2: begin
                        pos2_ff  <= mul_prod;
                        state_ff <= ST_CMP2;
                     end
                     MOP_NUMX: begin
                        num_ff <= mul_prod[NUM_W-1:0];
                        mop_ff <= MOP_NUMY;
                     end
                     MOP_NUMY: begin
                        num_ff <= mul_prod[NUM_W-1:0];
                        if (path_ff == ekc_pkg::PATH_3D) begin
                           mop_ff <= MOP_NUMZ;
                        end else begin
                           state_ff <= ST_DIVN;
                        end
                     end
                     default: begin
                        num_ff   <= mul_prod[NUM_W-1:0];
                        state_ff <= ST_DIVN;
                     end
                  endcase
               end
            end
            ST_CMP3: begin
               if (neg3_ff < pos3_ff) begin
                  path_ff  <= ekc_pkg::PATH_3D;
                  state_ff <= ST_SQRT;
               end else begin
                  mop_ff   <= MOP_POS2;
                  state_ff <= ST_MUL;
               end
            end
            ST_CMP2: begin
               if (neg2_ff < pos2_ff) begin
                  path_ff  <= ekc_pkg::PATH_XY;
                  state_ff <= ST_SQRT;
               end else if (uy_ff < ux_ff) begin
                  path_ff  <= ekc_pkg::PATH_Y;
                  nstep_ff <= ny_ff;
                  ustep_ff <= uy_ff;
                  state_ff <= ST_STEP;
               end else begin
                  path_ff  <= ekc_pkg::PATH_X;
                  nstep_ff <= nx_ff;
                  ustep_ff <= ux_ff;
                  state_ff <= ST_STEP;
               end
            end
            ST_SQRT: begin
               if (!run_ff) begin
                  run_ff <= 1'b1;
               end else if (sqrt_done) begin
                  run_ff   <= 1'b0;
                  root_ff  <= sqrt_root;
                  mop_ff   <= MOP_NUMX;
                  state_ff <= ST_MUL;
               end
            end
            ST_DIVN: begin
               if (!run_ff) begin
                  run_ff <= 1'b1;
               end else if (div_done) begin
                  run_ff      <= 1'b0;
                  res_time_ff <= sat_q(div_quot);
                  state_ff    <= ST_OUT;
               end
            end
            ST_STEP: begin
               if (!run_ff) begin
                  run_ff <= 1'b1;
               end else if (div_done) begin
                  run_ff      <= 1'b0;
                  res_time_ff <= step_sum[VAL_W] ? ekc_pkg::VAL_MAX : step_sum[VAL_W-1:0];
                  state_ff    <= ST_OUT;
               end
            end
            ST_OUT: begin
               // wait until the output word is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_time_ff  <= res_time_ff;
                  rsp_path_ff  <= path_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_new_time   = rsp_time_ff;
   assign rsp_solve_path = rsp_path_ff;

   // ---------------- assertions ----------------
   a_mul_free: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_busy)
      else $error("multiplier started while busy");

   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   a_sqrt_free: assert property (@(posedge clock) disable iff (reset)
      sqrt_start |-> !sqrt_busy)
      else $error("square root started while busy");

   a_read_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ && rd_cnt_ff == RD_LAST) |=> state_ff == ST_CHK)
      else $error("neighbor read phase did not end after six reads");

   a_zero_speed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHK && v_ff == '0) |=>
         (state_ff == ST_OUT && res_time_ff == ekc_pkg::VAL_MAX))
      else $error("zero speed did not saturate");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for the eikonal cell update block: grid loads and upwind solves.
module testbench;
   import ekc_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

   typedef struct {
      logic [FUNC_W-1:0]  func;
      logic [COORD_W-1:0] x, y, z;
      logic [VAL_W-1:0]   val;
   } cell_word_type;

   typedef struct {
      logic [VAL_W-1:0]  t;
      logic [PATH_W-1:0] path;
   } solve_word_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [FUNC_W-1:0]    req_func = '0;
   logic [COORD_W-1:0]   req_cell_x = '0, req_cell_y = '0, req_cell_z = '0;
   logic [VAL_W-1:0]     req_load_value = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [VAL_W-1:0]     rsp_new_time;
   logic [PATH_W-1:0]    rsp_solve_path;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CNT_W-1:0]     csr_wdata = '0;

   eikonal_cell_update_3d_top dut (.*);

   always #5 clock = ~clock;

   cell_word_type  pending_words[$];
   solve_word_type solved_times[$];
   logic [VAL_W-1:0] time_grid[int];
   logic [VAL_W-1:0] speed_grid[int];
   int unsigned nx = 64, ny = 64, nz = 1;
   int errors = 0;
   int path_hits[4] = '{0, 0, 0, 0};
   int n_updates = 0, n_words = 0;
   bit no_idle = 0;

   // ---------------- predictor ----------------
   function automatic int cell_at(int unsigned x, int unsigned y, int unsigned z);
      return (z * 64 + y) * 64 + x;
   endfunction

   function automatic int unsigned clamp_cnt(int unsigned c, int unsigned n);
      return (c >= n) ? n - 1 : c;
   endfunction

   function automatic int unsigned eff_count(logic [CNT_W-1:0] r);
      if (r == 0) return 1;
      return (r > 64) ? 64 : r;
   endfunction

   function automatic logic [127:0] isqrt(logic [127:0] n);
      logic [127:0] res, cand;
      res = '0;
      for (int b = 63; b >= 0; b--) begin
         cand = res | (128'd1 << b);
         if (!(n < cand * cand)) res = cand;
      end
      return res;
   endfunction

   function automatic logic [127:0] pair_cost(logic [127:0] wi, wj, a, b);
      logic [127:0] d;
      d = (a > b) ? a - b : b - a;
      return wi * d * (wj * d);
   endfunction

   function automatic logic [VAL_W-1:0] clip(logic [127:0] v);
      return (v > 128'(VAL_MAX)) ? VAL_MAX : v[VAL_W-1:0];
   endfunction

   function automatic solve_word_type solve_cell(int unsigned cx, cy, cz);
      int unsigned x, y, z;
      logic [127:0] v, f, ux, uy, uz, a, b, wx, wy, wz, w, pos, neg;
      solve_word_type r;
      x = clamp_cnt(cx, nx);
      y = clamp_cnt(cy, ny);
      z = clamp_cnt(cz, nz);
      v = 128'(speed_grid[cell_at(x, y, z)]);
      if (v == 0) begin
         r.t = VAL_MAX;
         r.path = PATH_3D;
         return r;
      end
      f = 128'(clip((128'd1 << 40) / v));
      a = 128'(time_grid[cell_at(x > 0 ? x - 1 : 0, y, z)]);
      b = 128'(time_grid[cell_at(clamp_cnt(x + 1, nx), y, z)]);
      ux = (a < b) ? a : b;
      a = 128'(time_grid[cell_at(x, y > 0 ? y - 1 : 0, z)]);
      b = 128'(time_grid[cell_at(x, clamp_cnt(y + 1, ny), z)]);
      uy = (a < b) ? a : b;
      a = 128'(time_grid[cell_at(x, y, z > 0 ? z - 1 : 0)]);
      b = 128'(time_grid[cell_at(x, y, clamp_cnt(z + 1, nz))]);
      uz = (a < b) ? a : b;
      wx = 128'(nx * nx);
      wy = 128'(ny * ny);
      wz = 128'(nz * nz);
      w = wx + wy + wz;
      pos = w * f * f;
      neg = pair_cost(wx, wy, ux, uy) + pair_cost(wy, wz, uy, uz) + pair_cost(wx, wz, ux, uz);
      if (neg < pos) begin
         r.t = clip((wx * ux + wy * uy + wz * uz + isqrt(pos - neg)) / w);
         r.path = PATH_3D;
         return r;
      end
      w = wx + wy;
      pos = w * f * f;
      neg = pair_cost(wx, wy, ux, uy);
      if (neg < pos) begin
         r.t = clip((wx * ux + wy * uy + isqrt(pos - neg)) / w);
         r.path = PATH_XY;
      end else if (uy < ux) begin
         r.t = clip(uy + f / ny);
         r.path = PATH_Y;
      end else begin
         r.t = clip(ux + f / nx);
         r.path = PATH_X;
      end
      return r;
   endfunction

   // ---------------- stimulus helpers ----------------
   function automatic logic [VAL_W-1:0] rand_time();
      case ($urandom_range(0, 5))
         0: return VAL_W'({$urandom, $urandom});
         1: return VAL_MAX - VAL_W'($urandom_range(0, 3));
         2: return VAL_W'($urandom_range(0, 1 << 30));
         default: return VAL_W'($urandom_range(0, 1 << 24));
      endcase
   endfunction

   function automatic logic [VAL_W-1:0] rand_speed();
      case ($urandom_range(0, 5))
         0: return VAL_W'({$urandom, $urandom});
         1: return VAL_W'($urandom_range(1, 16));
         2: return VAL_MAX;
         default: return VAL_W'((1 << 20) + $urandom_range(0, 1 << 22) - (1 << 19));
      endcase
   endfunction

   // the block keeps only the low coordinate bits
   task automatic push_load(logic [FUNC_W-1:0] fn, int unsigned x, y, z, logic [VAL_W-1:0] v);
      cell_word_type w;
      int unsigned mx, my, mz;
      mx = x & 63;
      my = y & 63;
      mz = z & 63;
      w.func = fn; w.x = COORD_W'(mx); w.y = COORD_W'(my); w.z = COORD_W'(mz); w.val = v;
      pending_words.push_back(w);
      if (fn == FUNC_LOAD_TIME) time_grid[cell_at(mx, my, mz)] = v;
      else speed_grid[cell_at(mx, my, mz)] = v;
   endtask

   task automatic push_time_if(int unsigned x, y, z);
      if (!time_grid.exists(cell_at(x, y, z)) || $urandom_range(0, 3) == 0)
         push_load(FUNC_LOAD_TIME, x, y, z, rand_time());
   endtask

   // loads whatever the solve will read that is still unwritten, some of it again at random, then the update
   task automatic push_update(int unsigned cx, cy, cz);
      int unsigned x, y, z;
      cell_word_type w;
      solve_word_type r;
      x = clamp_cnt(cx, nx);
      y = clamp_cnt(cy, ny);
      z = clamp_cnt(cz, nz);
      if (!speed_grid.exists(cell_at(x, y, z)) || $urandom_range(0, 3) == 0)
         push_load(FUNC_LOAD_SPEED, x, y, z, rand_speed());
      push_time_if(x > 0 ? x - 1 : 0, y, z);
      push_time_if(clamp_cnt(x + 1, nx), y, z);
      push_time_if(x, y > 0 ? y - 1 : 0, z);
      push_time_if(x, clamp_cnt(y + 1, ny), z);
      push_time_if(x, y, z > 0 ? z - 1 : 0);
      push_time_if(x, y, clamp_cnt(z + 1, nz));
      w.func = FUNC_UPDATE; w.x = COORD_W'(cx); w.y = COORD_W'(cy); w.z = COORD_W'(cz);
      w.val = VAL_W'({$urandom, $urandom});
      pending_words.push_back(w);
      r = solve_cell(x, y, z);
      solved_times.push_back(r);
   endtask

   function automatic int unsigned rand_coord();
      case ($urandom_range(0, 7))
         0: return 63;
         1: return $urandom_range(0, 63);
         default: return $urandom_range(0, 3);
      endcase
   endfunction

   task automatic push_noise();
      cell_word_type w;
      w.func = FUNC_NONE;
      w.x = COORD_W'($urandom); w.y = COORD_W'($urandom); w.z = COORD_W'($urandom);
      w.val = VAL_W'({$urandom, $urandom});
      pending_words.push_back(w);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CNT_W-1:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_CELLS_X: nx = eff_count(v);
         CSR_CELLS_Y: ny = eff_count(v);
         default:     nz = eff_count(v);
      endcase
   endtask

   task automatic drain();
      while (pending_words.size() > 0 || req_valid || solved_times.size() > 0)
         @(posedge clock);
      // loads after the last result may still be in flight
      repeat (50) @(posedge clock);
   endtask

   // ---------------- driver ----------------
   int unsigned req_gap = 0;
   always @(posedge clock) begin : drive_words
      cell_word_type w;
      logic nv;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         nv = req_valid;
         if (req_valid && req_ready) begin
            nv = 1'b0;
            n_words++;
         end
         if (!nv) begin
            if (req_gap > 0) req_gap--;
            else if (pending_words.size() > 0) begin
               w = pending_words.pop_front();
               req_func <= w.func;
               req_cell_x <= w.x;
               req_cell_y <= w.y;
               req_cell_z <= w.z;
               req_load_value <= w.val;
               nv = 1'b1;
               req_gap = no_idle ? 0 : $urandom_range(0, 12);
            end
         end
         req_valid <= nv;
      end
   end

   // ---------------- monitor ----------------
   int unsigned rsp_stall = 0;
   always @(posedge clock) begin : check_words
      solve_word_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (solved_times.size() == 0) begin
               $error("result with nothing pending: new_time %0h", rsp_new_time);
               errors++;
            end else begin
               e = solved_times.pop_front();
               n_updates++;
               path_hits[rsp_solve_path]++;
               if (rsp_new_time !== e.t) begin
                  $error("new_time expected %0h actual %0h", e.t, rsp_new_time);
                  errors++;
               end
               if (rsp_solve_path !== e.path) begin
                  $error("solve_path expected %0d actual %0d", e.path, rsp_solve_path);
                  errors++;
               end
            end
            rsp_stall = no_idle ? 0 : $urandom_range(0, 12);
         end else if (rsp_stall > 0) rsp_stall--;
         rsp_ready <= (rsp_stall == 0);
      end
   end

   // ---------------- sequence ----------------
   int cfg_x[8] = '{0, 127, 64, 1, 5, 64, 2, 0};
   int cfg_y[8] = '{0, 127, 64, 64, 3, 1, 64, 0};
   int cfg_z[8] = '{0, 127, 64, 2, 7, 64, 1, 0};

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: corners, extremes of values, zero speed, unused code
      push_update(0, 0, 0);
      push_update(63, 63, 63);
      push_load(FUNC_LOAD_SPEED, 5, 5, 0, '0);
      push_update(5, 5, 0);
      push_load(FUNC_LOAD_SPEED, 1, 1, 0, VAL_MAX);
      push_load(FUNC_LOAD_TIME, 0, 1, 0, VAL_MAX);
      push_load(FUNC_LOAD_TIME, 2, 1, 0, VAL_MAX);
      push_update(1, 1, 0);
      push_load(FUNC_LOAD_SPEED, 2, 2, 0, 40'd1);
      push_update(2, 2, 0);
      push_load(FUNC_LOAD_TIME, 63, 63, 63, VAL_MAX);
      push_noise();
      push_update(62, 40, 9);
      drain();

      for (int p = 0; p < 9; p++) begin
         if (p > 0) begin
            if (p == 8) begin
               cfg_x[7] = $urandom_range(0, 127);
               cfg_y[7] = $urandom_range(0, 127);
               cfg_z[7] = $urandom_range(0, 127);
            end
            write_csr(CSR_CELLS_X, CNT_W'(cfg_x[p-1]));
            write_csr(CSR_CELLS_Y, CNT_W'(cfg_y[p-1]));
            write_csr(CSR_CELLS_Z, CNT_W'(cfg_z[p-1]));
         end
         no_idle = (p % 3 == 2);
         for (int i = 0; i < 12; i++) begin
            case ($urandom_range(0, 9))
               0: push_noise();
               1: push_load(FUNC_LOAD_TIME, $urandom, $urandom, $urandom, rand_time());
               default: push_update(rand_coord(), rand_coord(), rand_coord());
            endcase
         end
         drain();
      end

      $display("covered %0d words, %0d updates; paths 3d %0d xy %0d y %0d x %0d",
               n_words, n_updates, path_hits[0], path_hits[1], path_hits[2], path_hits[3]);
      $display("cell count settings include 0, 1, 64 and 127 on every axis");
      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule

/* eikonal_cell_update_3d_top.f */
rtl/core/ekc_pkg.sv
rtl/core/ekc_ram.sv
rtl/core/ekc_mul.sv
rtl/core/ekc_div.sv
rtl/core/ekc_sqrt.sv
rtl/core/eikonal_cell_update_3d_top.sv
dv/testbench.sv
